@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i, reset on rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SACL_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define SACL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/sacl_pkg.sv @@
// ----------------------------------------------------------------------------
// sacl_pkg
// Types and constants of the set-associative cache tag engine.
// ----------------------------------------------------------------------------
package sacl_pkg;

  localparam int ADDR_W           = 32;
  localparam int STAT_W           = 32;
  localparam int WAY_IDX_W        = 3;
  localparam int DEF_WAYS         = 4;
  localparam int DEF_SETS         = 256;
  localparam int DEF_BLOCK_BYTES  = 32;
  localparam int DEF_COUNT_BITS   = 16;
  localparam int S_TDATA_W        = 32;
  localparam int S_TUSER_W        = 2;
  localparam int M_TDATA_W        = 168;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef enum logic {
    POL_LRU = 1'b0,
    POL_LFU = 1'b1
  } policy_e;

  typedef struct packed {
    logic              dirty_in;
    op_e               opcode;
    logic [ADDR_W-1:0] address;
  } req_t;

  // lowest field in lowest bits
  typedef struct packed {
    logic [STAT_W-1:0]    writebacks_total;
    logic [STAT_W-1:0]    write_misses_total;
    logic [STAT_W-1:0]    read_misses_total;
    logic [STAT_W-1:0]    writes_total;
    logic [STAT_W-1:0]    reads_total;
    logic [WAY_IDX_W-1:0] victim_way;
    logic                 writeback;
    logic                 hit;
  } res_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

@@ hw/rtl/sacl_ram.sv @@
// ----------------------------------------------------------------------------
// sacl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sacl_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/sacl_front.sv @@
// ----------------------------------------------------------------------------
// sacl_front
// Request intake: takes access requests and queues them for the back end.
// ----------------------------------------------------------------------------
module sacl_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [sacl_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input  logic [sacl_pkg::S_TUSER_W-1:0] s_axis_tuser,
  input  sacl_pkg::back_status_t         status_i,
  output logic                           q_valid_o,
  output sacl_pkg::req_t                 q_req_o,
  input  logic                           q_pop_i
);
  import sacl_pkg::*;

  req_t       buf_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  req_t       req_in;

  always_comb begin
    req_in          = '0;
    req_in.address  = s_axis_tdata;
    req_in.opcode   = op_e'(s_axis_tuser[0]);
    req_in.dirty_in = s_axis_tuser[1];
  end

  assign s_axis_tready = (cnt_q != 2'd2) && !status_i.clearing;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid_o     = (cnt_q != 2'd0);
  assign q_req_o       = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !q_pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (!push && q_pop_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= req_in;
    end
  end

endmodule

@@ hw/rtl/sacl_back.sv @@
// ----------------------------------------------------------------------------
// sacl_back
// Lookup and update engine: reads a set row, compares tags, picks the
// victim, writes the row back and registers the result.
// ----------------------------------------------------------------------------
module sacl_back #(
  parameter int Ways       = sacl_pkg::DEF_WAYS,
  parameter int Sets       = sacl_pkg::DEF_SETS,
  parameter int BlockBytes = sacl_pkg::DEF_BLOCK_BYTES,
  parameter int CountBits  = sacl_pkg::DEF_COUNT_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_data_i,
  input  logic                   q_valid_i,
  input  sacl_pkg::req_t         q_req_i,
  output logic                   q_pop_o,
  output sacl_pkg::back_status_t status_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output sacl_pkg::res_t         out_res_o
);
  import sacl_pkg::*;

  localparam int OffW    = $clog2(BlockBytes);
  localparam int LogSets = $clog2(Sets);
  localparam int SetW    = (Sets > 1) ? LogSets : 1;
  localparam int TagW    = ADDR_W - OffW - LogSets;
  localparam int EntW    = TagW + 2 + CountBits;
  localparam int RowW    = Ways * EntW;
  localparam int WiW     = (Ways > 1) ? $clog2(Ways) : 1;
  localparam logic [CountBits-1:0] CntMax = {CountBits{1'b1}};

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } state_e;

  function automatic logic [CountBits-1:0] sat_inc(input logic [CountBits-1:0] v);
    return (v == CntMax) ? v : v + 1'b1;
  endfunction

  state_e            state_q;
  logic [SetW-1:0]   clr_q;
  policy_e           policy_q;
  req_t              req_q;
  logic [SetW-1:0]   set_q;
  logic [TagW-1:0]   tag_q;
  logic [STAT_W-1:0] rd_cnt_q, wr_cnt_q, rmiss_q, wmiss_q, wb_cnt_q;
  logic              out_valid_q;
  res_t              out_q;

  logic              ram_we, ram_re;
  logic [SetW-1:0]   ram_waddr, ram_raddr;
  logic [RowW-1:0]   ram_wdata, ram_rdata, clr_row, new_row;
  logic              fire;

  logic [TagW-1:0]      tag_a  [Ways];
  logic                 val_a  [Ways];
  logic                 dty_a  [Ways];
  logic [CountBits-1:0] cnt_a  [Ways];
  logic [CountBits-1:0] ncnt_a [Ways];
  logic                 hit;
  logic [WiW-1:0]       hit_way, lru_way, lfu_way, vway;
  logic [CountBits-1:0] best, mn, ref_cnt;
  logic                 lfu_found, wb;
  logic [STAT_W-1:0]    rd_cnt_d, wr_cnt_d, rmiss_d, wmiss_d, wb_cnt_d;

  sacl_ram #(
    .Width (RowW),
    .Depth (Sets)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // entry layout: {tag, valid, dirty, count}
  always_comb begin
    for (int w = 0; w < Ways; w++) begin
      cnt_a[w] = ram_rdata[w*EntW +: CountBits];
      dty_a[w] = ram_rdata[w*EntW + CountBits];
      val_a[w] = ram_rdata[w*EntW + CountBits + 1];
      tag_a[w] = ram_rdata[w*EntW + CountBits + 2 +: TagW];
      clr_row[w*EntW +: EntW] = {{TagW{1'b0}}, 2'b00,
        (policy_q == POL_LRU) ? CountBits'(Ways - 1 - w) : {CountBits{1'b0}}};
    end
  end

  always_comb begin
    hit       = 1'b0;
    hit_way   = '0;
    best      = '0;
    lru_way   = '0;
    mn        = cnt_a[0];
    lfu_way   = '0;
    lfu_found = 1'b0;
    for (int w = 0; w < Ways; w++) begin
      if (!hit && val_a[w] && tag_a[w] == tag_q) begin
        hit     = 1'b1;
        hit_way = WiW'(w);
      end
      // ties go to the highest-numbered way
      if (cnt_a[w] >= best) begin
        best    = cnt_a[w];
        lru_way = WiW'(w);
      end
      if (cnt_a[w] < mn) begin
        mn = cnt_a[w];
      end
    end
    for (int w = 0; w < Ways; w++) begin
      if (!lfu_found && (!val_a[w] || cnt_a[w] == mn)) begin
        lfu_found = 1'b1;
        lfu_way   = WiW'(w);
      end
    end
    if (hit) begin
      vway = hit_way;
    end else if (policy_q == POL_LRU) begin
      vway = lru_way;
    end else begin
      vway = lfu_way;
    end
  end

  always_comb begin
    ref_cnt = cnt_a[vway];
    wb      = !hit && val_a[vway] && dty_a[vway];
    for (int w = 0; w < Ways; w++) begin
      ncnt_a[w] = cnt_a[w];
      if (policy_q == POL_LRU) begin
        if (WiW'(w) == vway) begin
          ncnt_a[w] = '0;
        end else if (!hit || cnt_a[w] < ref_cnt) begin
          ncnt_a[w] = sat_inc(cnt_a[w]);
        end
      end else if (WiW'(w) == vway) begin
        ncnt_a[w] = sat_inc(cnt_a[w]);
      end
    end
    for (int w = 0; w < Ways; w++) begin
      new_row[w*EntW +: CountBits]      = ncnt_a[w];
      new_row[w*EntW + CountBits]       = dty_a[w];
      new_row[w*EntW + CountBits + 1]   = val_a[w];
      new_row[w*EntW + CountBits + 2 +: TagW] = tag_a[w];
      if (WiW'(w) == vway) begin
        if (hit) begin
          new_row[w*EntW + CountBits] = dty_a[w] | req_q.dirty_in;
        end else begin
          new_row[w*EntW + CountBits]             = req_q.dirty_in;
          new_row[w*EntW + CountBits + 1]         = 1'b1;
          new_row[w*EntW + CountBits + 2 +: TagW] = tag_q;
        end
      end
    end
  end

  always_comb begin
    rd_cnt_d = rd_cnt_q;
    wr_cnt_d = wr_cnt_q;
    rmiss_d  = rmiss_q;
    wmiss_d  = wmiss_q;
    wb_cnt_d = wb_cnt_q + STAT_W'(wb);
    if (req_q.opcode == OP_WRITE) begin
      wr_cnt_d = wr_cnt_q + 1'b1;
      wmiss_d  = wmiss_q + STAT_W'(!hit);
    end else begin
      rd_cnt_d = rd_cnt_q + 1'b1;
      rmiss_d  = rmiss_q + STAT_W'(!hit);
    end
  end

  assign fire      = (state_q == ST_LOOK) && (!out_valid_q || out_ready_i);
  assign q_pop_o   = (state_q == ST_IDLE) && q_valid_i;
  assign ram_re    = q_pop_o;
  assign ram_raddr = SetW'(q_req_i.address >> OffW) & SetW'(Sets - 1);
  assign ram_we    = (state_q == ST_CLEAR) || fire;
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : set_q;
  assign ram_wdata = (state_q == ST_CLEAR) ? clr_row : new_row;

  assign status_o.clearing = (state_q == ST_CLEAR);
  assign out_valid_o       = out_valid_q;
  assign out_res_o         = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      policy_q    <= POL_LRU;
      req_q       <= '0;
      set_q       <= '0;
      tag_q       <= '0;
      rd_cnt_q    <= '0;
      wr_cnt_q    <= '0;
      rmiss_q     <= '0;
      wmiss_q     <= '0;
      wb_cnt_q    <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == SetW'(Sets - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_valid_i) begin
            req_q   <= q_req_i;
            set_q   <= ram_raddr;
            tag_q   <= TagW'(q_req_i.address >> (OffW + LogSets));
            state_q <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (fire) begin
            rd_cnt_q                 <= rd_cnt_d;
            wr_cnt_q                 <= wr_cnt_d;
            rmiss_q                  <= rmiss_d;
            wmiss_q                  <= wmiss_d;
            wb_cnt_q                 <= wb_cnt_d;
            out_valid_q              <= 1'b1;
            out_q.hit                <= hit;
            out_q.writeback          <= wb;
            out_q.victim_way         <= WAY_IDX_W'(vway);
            out_q.reads_total        <= rd_cnt_d;
            out_q.writes_total       <= wr_cnt_d;
            out_q.read_misses_total  <= rmiss_d;
            out_q.write_misses_total <= wmiss_d;
            out_q.writebacks_total   <= wb_cnt_d;
            state_q                  <= ST_IDLE;
          end
        end
        default: state_q <= ST_CLEAR;
      endcase
      // policy change wipes the store
      if (cfg_valid_i) begin
        policy_q <= policy_e'(cfg_data_i);
        clr_q    <= '0;
        state_q  <= ST_CLEAR;
      end
    end
  end

endmodule

@@ hw/rtl/set_assoc_cache_lru_lfu_core.sv @@
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lfu_core
// Tag and state engine of a write-back, write-allocate set-associative cache.
// ----------------------------------------------------------------------------
// Each access passes through the back-end states IDLE, which reads the set
// row from the row RAM, and LOOK, which compares the ways, picks the victim
// and writes the row back; this single read/update of the set row sets the
// rate. A two-entry queue sits in front, and a result register lets the next
// access be taken and its row read while a result waits on m_axis; LOOK then
// stalls until that result is accepted. After reset and after every write of
// the policy register, a clearing pass over all SETS rows initializes them;
// s_axis_tready stays low during it. Statistics counters survive policy writes.
module set_assoc_cache_lru_lfu_core #(
  parameter int Ways       = sacl_pkg::DEF_WAYS,
  parameter int Sets       = sacl_pkg::DEF_SETS,
  parameter int BlockBytes = sacl_pkg::DEF_BLOCK_BYTES,
  parameter int CountBits  = sacl_pkg::DEF_COUNT_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_data_i,     // replacement_policy
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [sacl_pkg::S_TDATA_W-1:0] s_axis_tdata,   // address
  input  logic [sacl_pkg::S_TUSER_W-1:0] s_axis_tuser,   // opcode, dirty_in
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // hit, writeback, victim_way, reads_total, writes_total,
  // read_misses_total, write_misses_total, writebacks_total, zero pad
  output logic [sacl_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import sacl_pkg::*;

  logic         q_valid, q_pop;
  req_t         q_req;
  back_status_t status;
  res_t         res;

  assign cfg_ready_o = 1'b1;

  sacl_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .status_i      (status),
    .q_valid_o     (q_valid),
    .q_req_o       (q_req),
    .q_pop_i       (q_pop)
  );

  sacl_back #(
    .Ways       (Ways),
    .Sets       (Sets),
    .BlockBytes (BlockBytes),
    .CountBits  (CountBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_req_i     (q_req),
    .q_pop_o     (q_pop),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  assign m_axis_tdata = M_TDATA_W'(res);

endmodule

@@ hw/rtl/sacl_checker.sv @@
// ----------------------------------------------------------------------------
// sacl_checker
// Port-level checks of the cache tag engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sacl_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [sacl_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  `SACL_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `SACL_ASSERT_NXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  // a hit never evicts
  `SACL_ASSERT(a_hit_no_wb, m_axis_tvalid, !(m_axis_tdata[0] && m_axis_tdata[1]))
  // a policy write starts the clearing pass
  `SACL_ASSERT_NXT(a_cfg_clears, cfg_valid_i && cfg_ready_o, !s_axis_tready)

endmodule

bind set_assoc_cache_lru_lfu_core sacl_checker u_sacl_checker (.*);
